@@ src/bad_pkg.sv @@
// Shared types and constants of the box average downscaler.
`default_nettype none

package bad_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned MAX_RATE_DEF  = 8;
  localparam int unsigned HEIGHT_CAP    = 1024;
  localparam int unsigned PIX_MAX       = 255;
  localparam int unsigned CHAN_W        = 8;
  localparam int unsigned NUM_CHAN      = 4;
  localparam int unsigned CFG_DATA_W    = 11;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned RATE_REG_W    = 4;
  localparam int unsigned HEIGHT_W      = $clog2(HEIGHT_CAP + 1);
  localparam int unsigned ROW_W         = $clog2(HEIGHT_CAP);

  localparam logic [RATE_REG_W-1:0] RATE_RST   = 4'd2;
  localparam logic [CFG_DATA_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = 11'd440;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_RATE   = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CFG,
    ST_UPDATE,
    ST_DIVIDE
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic cfg_start;
    logic cfg_load;
    logic ram_we;
    logic div_start;
    logic out_load;
  } ctrl_t;

endpackage

`default_nettype wire

@@ src/box_average_downscale.sv @@
// Top level of the box average downscaler: counters, control and output register.
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+-----------------------------------
//  s_axis   | in        | s_axis_tvalid/s_axis_tready | tdata: ARGB pixel
//  m_axis   | out       | m_axis_tvalid/m_axis_tready | tdata: ARGB average, tlast, tuser
//  cfg      | in        | cfg_we_i                    | cfg_idx_i, cfg_data_i
//
// For a pixel that gives no result the column sum is read, then written back.
// A pixel that closes a cell also runs the bit-serial divider of the average over
// the SW-bit column sums (SW = column sum width, 14 at the default MAX_RATE).
// After reset and after every config write the cell limits are recomputed by
// bit-serial dividers over the width and height words; s_axis_tready stays
// low meanwhile. The result waits in an output register; a new pixel is taken
// while it waits, and only a second finished cell waits for it.
`default_nettype none

module box_average_downscale
  import bad_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int unsigned MAX_RATE  = MAX_RATE_DEF
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  // in_alpha[7:0], in_red[15:8], in_green[23:16], in_blue[31:24]
  input  wire [31:0]            s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  // out_alpha[7:0], out_red[15:8], out_green[23:16], out_blue[31:24]
  output logic [31:0]           m_axis_tdata,
  // row_end
  output logic                  m_axis_tlast,
  // frame_end[0]
  output logic                  m_axis_tuser,
  input  wire                   cfg_we_i,
  input  wire [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned AW    = $clog2(MAX_WIDTH);
  localparam int unsigned PCW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW    = $clog2(MAX_RATE + 1);
  localparam int unsigned PW    = $clog2(MAX_RATE);
  localparam int unsigned SW    = $clog2(MAX_RATE * MAX_RATE * PIX_MAX + 1);
  localparam int unsigned AREAW = $clog2(MAX_RATE * MAX_RATE + 1);
  localparam int unsigned MW    = NUM_CHAN * SW;

  // configuration registers
  logic [RATE_REG_W-1:0] scale_rate_q;
  logic [CFG_DATA_W-1:0] frame_width_q;
  logic [CFG_DATA_W-1:0] frame_height_q;
  logic                  cfg_pend_q, cfg_pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_rate_q   <= RATE_RST;
      frame_width_q  <= WIDTH_RST;
      frame_height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SCALE_RATE:   scale_rate_q   <= cfg_data_i[RATE_REG_W-1:0];
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped settings
  logic [RW-1:0]       rate_c;
  logic [PCW-1:0]      width_c;
  logic [HEIGHT_W-1:0] height_c;
  logic [2*RW-1:0]     rate_sq;
  logic [AREAW-1:0]    area;

  always_comb begin
    if (scale_rate_q == '0) begin
      rate_c = RW'(1);
    end else if (32'(scale_rate_q) > MAX_RATE) begin
      rate_c = RW'(MAX_RATE);
    end else begin
      rate_c = RW'(scale_rate_q);
    end
    if (frame_width_q == '0) begin
      width_c = PCW'(1);
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      width_c = PCW'(MAX_WIDTH);
    end else begin
      width_c = PCW'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      height_c = HEIGHT_W'(1);
    end else if (32'(frame_height_q) > HEIGHT_CAP) begin
      height_c = HEIGHT_W'(HEIGHT_CAP);
    end else begin
      height_c = HEIGHT_W'(frame_height_q);
    end
    rate_sq = {{RW{1'b0}}, rate_c} * {{RW{1'b0}}, rate_c};
    area    = AREAW'(rate_sq);
  end

  // FSM
  state_e state_q, state_d;
  ctrl_t  ctrl;
  logic   accept;
  logic   cfg_done;
  logic   avg_done;
  logic   out_free;

  logic            act_q, fresh_q, emit_q, rend_q, fend_q;
  logic [AW-1:0]   addr_q;
  logic [31:0]     px_q;
  logic            m_valid_q;

  assign out_free = !m_valid_q || m_axis_tready;
  assign accept   = s_axis_tvalid && ctrl.in_ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cfg_pend_q) begin
          state_d = ST_CFG;
        end else if (s_axis_tvalid) begin
          state_d = ST_UPDATE;
        end
      end
      ST_CFG: begin
        if (cfg_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_UPDATE: begin
        state_d = (act_q && emit_q) ? ST_DIVIDE : ST_IDLE;
      end
      ST_DIVIDE: begin
        if (avg_done && out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state_q)
      ST_IDLE: begin
        ctrl.in_ready  = !cfg_pend_q;
        ctrl.cfg_start = cfg_pend_q;
      end
      ST_CFG: begin
        ctrl.cfg_load = cfg_done;
      end
      ST_UPDATE: begin
        ctrl.ram_we    = act_q;
        ctrl.div_start = act_q && emit_q;
      end
      ST_DIVIDE: begin
        ctrl.out_load = avg_done && out_free;
      end
      default: ;
    endcase
  end

  assign s_axis_tready = ctrl.in_ready;

  always_comb begin
    cfg_pend_d = cfg_pend_q;
    if (cfg_we_i) begin
      cfg_pend_d = 1'b1;
    end else if (ctrl.cfg_start) begin
      cfg_pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cfg_pend_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      cfg_pend_q <= cfg_pend_d;
    end
  end

  // cell limits: cells per row and rows in whole cells
  logic [PCW-1:0]      wq;
  logic [HEIGHT_W-1:0] hq;
  logic                wdone, hdone;
  logic [PCW-1:0]      cells_x_q;
  logic [HEIGHT_W-1:0] rows_used_q;
  logic [HEIGHT_W+RW-1:0] rows_prod;

  bad_div #(.NW(PCW), .DW(RW)) u_wdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl.cfg_start),
    .dividend_i (width_c),
    .divisor_i  (rate_c),
    .quotient_o (wq),
    .done_o     (wdone)
  );

  bad_div #(.NW(HEIGHT_W), .DW(RW)) u_hdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl.cfg_start),
    .dividend_i (height_c),
    .divisor_i  (rate_c),
    .quotient_o (hq),
    .done_o     (hdone)
  );

  assign cfg_done  = wdone && hdone;
  assign rows_prod = {{RW{1'b0}}, hq} * {{HEIGHT_W{1'b0}}, rate_c};

  always_ff @(posedge clk_i) begin
    if (ctrl.cfg_load) begin
      cells_x_q   <= wq;
      rows_used_q <= HEIGHT_W'(rows_prod);
    end
  end

  // raster counters
  logic [AW-1:0]   pix_col_q, pix_col_d;
  logic [ROW_W-1:0] pix_row_q, pix_row_d;
  logic [PW-1:0]   col_ph_q, col_ph_d;
  logic [PW-1:0]   row_ph_q, row_ph_d;
  logic [AW-1:0]   cell_col_q, cell_col_d;
  logic [PW:0]     col_ph_inc, row_ph_inc;
  logic [AW:0]     pix_col_inc, cell_col_inc;
  logic [ROW_W:0]  pix_row_inc;
  logic            in_cell, emit, rend, fend;

  always_comb begin
    col_ph_inc   = {1'b0, col_ph_q} + (PW+1)'(1);
    row_ph_inc   = {1'b0, row_ph_q} + (PW+1)'(1);
    pix_col_inc  = {1'b0, pix_col_q} + (AW+1)'(1);
    cell_col_inc = {1'b0, cell_col_q} + (AW+1)'(1);
    pix_row_inc  = {1'b0, pix_row_q} + (ROW_W+1)'(1);

    in_cell = (cell_col_q < cells_x_q) && (pix_row_q < rows_used_q);
    emit    = (col_ph_inc >= rate_c) && (row_ph_inc >= rate_c);
    rend    = cell_col_inc >= cells_x_q;
    fend    = rend && (pix_row_inc >= rows_used_q);

    pix_col_d  = pix_col_inc[AW-1:0];
    pix_row_d  = pix_row_q;
    row_ph_d   = row_ph_q;
    if (col_ph_inc >= rate_c) begin
      col_ph_d   = '0;
      cell_col_d = cell_col_inc[AW-1:0];
    end else begin
      col_ph_d   = col_ph_inc[PW-1:0];
      cell_col_d = cell_col_q;
    end
    if (pix_col_inc >= width_c) begin
      pix_col_d  = '0;
      col_ph_d   = '0;
      cell_col_d = '0;
      row_ph_d   = (row_ph_inc >= rate_c) ? '0 : row_ph_inc[PW-1:0];
      pix_row_d  = pix_row_inc[ROW_W-1:0];
      if (pix_row_inc >= height_c) begin
        pix_row_d = '0;
        row_ph_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_col_q  <= '0;
      pix_row_q  <= '0;
      col_ph_q   <= '0;
      row_ph_q   <= '0;
      cell_col_q <= '0;
      act_q      <= 1'b0;
      emit_q     <= 1'b0;
    end else if (accept) begin
      pix_col_q  <= pix_col_d;
      pix_row_q  <= pix_row_d;
      col_ph_q   <= col_ph_d;
      row_ph_q   <= row_ph_d;
      cell_col_q <= cell_col_d;
      act_q      <= in_cell;
      emit_q     <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q    <= s_axis_tdata;
      addr_q  <= cell_col_q;
      fresh_q <= (col_ph_q == '0) && (row_ph_q == '0);
      rend_q  <= rend;
      fend_q  <= fend;
    end
  end

  // column sum store, read at accept, written back in the next cycle
  logic [MW-1:0] rdata;
  logic [MW-1:0] wdata;

  bad_ram #(.WIDTH(MW), .DEPTH(MAX_WIDTH)) u_sums (
    .clk_i   (clk_i),
    .we_i    (ctrl.ram_we),
    .waddr_i (addr_q),
    .wdata_i (wdata),
    .re_i    (accept && in_cell),
    .raddr_i (cell_col_q),
    .rdata_o (rdata)
  );

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      wdata[c*SW +: SW] = fresh_q ? SW'(px_q[c*CHAN_W +: CHAN_W])
                                  : rdata[c*SW +: SW] + SW'(px_q[c*CHAN_W +: CHAN_W]);
    end
  end

  // cell averages
  logic [SW-1:0]       quo  [NUM_CHAN];
  logic [NUM_CHAN-1:0] lane_done;
  logic [31:0]         avg_px;

  for (genvar g = 0; g < NUM_CHAN; g++) begin : g_lane
    bad_div #(.NW(SW), .DW(AREAW)) u_avg (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (ctrl.div_start),
      .dividend_i (wdata[g*SW +: SW]),
      .divisor_i  (area),
      .quotient_o (quo[g]),
      .done_o     (lane_done[g])
    );
    assign avg_px[g*CHAN_W +: CHAN_W] = (quo[g] > SW'(PIX_MAX)) ? CHAN_W'(PIX_MAX)
                                                                 : quo[g][CHAN_W-1:0];
  end

  assign avg_done = &lane_done;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      m_axis_tdata <= avg_px;
      m_axis_tlast <= rend_q;
      m_axis_tuser <= fend_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;

endmodule

`default_nettype wire

@@ src/bad_ram.sv @@
// Generic single-port-write, registered-read RAM.
`default_nettype none

module bad_ram #(
  parameter int unsigned WIDTH = 56,
  parameter int unsigned DEPTH = 1024
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire [WIDTH-1:0]           wdata_i,
  input  wire                       re_i,
  input  wire [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ src/bad_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module bad_div
  import bad_pkg::*;
#(
  parameter int unsigned NW = 14,
  parameter int unsigned DW = 7
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  input  wire [NW-1:0]     dividend_i,
  input  wire [DW-1:0]     divisor_i,
  output logic [NW-1:0]    quotient_o,
  output logic             done_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] div_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [DW:0]   trial;
  logic          fits;

  always_comb begin
    trial = {rem_q, quo_q[NW-1]};
    fits  = trial >= {1'b0, div_q};
    rem_d = fits ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];
    quo_d = {quo_q[NW-2:0], fits};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = CW'(NW);
    end else if (busy_q) begin
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Testbench of the box average downscaler: frames checked against a cell-average predictor.
`default_nettype none

module tb
  import bad_pkg::*;
();

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned DRAIN_LIMIT   = 100000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned RANDOM_ITEMS  = 60;

  typedef struct {
    logic [31:0] data;
    logic        row_end;
    logic        frame_end;
  } avg_pix_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [31:0]           m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // register shadows
  logic [RATE_REG_W-1:0] rate_reg   = RATE_RST;
  logic [CFG_DATA_W-1:0] width_reg  = WIDTH_RST;
  logic [CFG_DATA_W-1:0] height_reg = HEIGHT_RST;

  // predictor state
  int unsigned col_sum [MAX_WIDTH_DEF][NUM_CHAN];
  int unsigned pix_col  = 0;
  int unsigned pix_row  = 0;
  int unsigned col_ph   = 0;
  int unsigned row_ph   = 0;
  int unsigned cell_col = 0;

  avg_pix_t    pending_avgs [$];
  avg_pix_t    oldest_avg;
  int unsigned err_count    = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  logic        rx_hold      = 1'b0;

  box_average_downscale DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned clamp_to(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic predict_cell_average(input logic [31:0] pix);
    int unsigned r, w, h, cells_x, rows_used, q;
    int c;
    avg_pix_t avg;
    r = clamp_to(32'(rate_reg), MAX_RATE_DEF);
    w = clamp_to(32'(width_reg), MAX_WIDTH_DEF);
    h = clamp_to(32'(height_reg), HEIGHT_CAP);
    cells_x = w / r;
    rows_used = (h / r) * r;
    if (cell_col < cells_x && pix_row < rows_used) begin
      for (c = 0; c < NUM_CHAN; c++) begin
        if (col_ph == 0 && row_ph == 0) begin
          col_sum[cell_col][c] = 32'(pix[c*CHAN_W +: CHAN_W]);
        end else begin
          col_sum[cell_col][c] = col_sum[cell_col][c] + 32'(pix[c*CHAN_W +: CHAN_W]);
        end
      end
      if (col_ph + 1 >= r && row_ph + 1 >= r) begin
        for (c = 0; c < NUM_CHAN; c++) begin
          q = col_sum[cell_col][c] / (r * r);
          avg.data[c*CHAN_W +: CHAN_W] = CHAN_W'((q > PIX_MAX) ? PIX_MAX : q);
        end
        avg.row_end = (cell_col + 1 >= cells_x);
        avg.frame_end = avg.row_end && (pix_row + 1 >= rows_used);
        pending_avgs.push_back(avg);
      end
    end
    col_ph++;
    if (col_ph >= r) begin
      col_ph = 0;
      cell_col++;
    end
    pix_col++;
    if (pix_col >= w) begin
      pix_col = 0;
      col_ph = 0;
      cell_col = 0;
      row_ph++;
      if (row_ph >= r) row_ph = 0;
      pix_row++;
      if (pix_row >= h) begin
        pix_row = 0;
        row_ph = 0;
      end
    end
  endtask

  task automatic send_pixel(input logic [31:0] pix);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_cell_average(pix);
  endtask

  task automatic send_frames(input int unsigned n_frames);
    int unsigned total;
    total = clamp_to(32'(width_reg), MAX_WIDTH_DEF) * clamp_to(32'(height_reg), HEIGHT_CAP)
            * n_frames;
    repeat (total) send_pixel(rand_pixel());
  endtask

  task automatic finish_traffic();
    int unsigned n;
    s_axis_tvalid <= 1'b0;
    n = 0;
    while (pending_avgs.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    if (pending_avgs.size() != 0) begin
      $display("%0t: %0d results missing, expected %h, actual none",
               $realtime, pending_avgs.size(), pending_avgs[0].data);
      err_count++;
      pending_avgs.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_SCALE_RATE:   rate_reg   = data[RATE_REG_W-1:0];
      REG_FRAME_WIDTH:  width_reg  = data;
      REG_FRAME_HEIGHT: height_reg = data;
      default: ;
    endcase
  endtask

  task automatic prepare_config(input logic [CFG_DATA_W-1:0] rate,
                                input logic [CFG_DATA_W-1:0] width,
                                input logic [CFG_DATA_W-1:0] height);
    finish_traffic();
    write_reg(REG_SCALE_RATE, rate);
    write_reg(REG_FRAME_WIDTH, width);
    write_reg(REG_FRAME_HEIGHT, height);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_single_pixel_frames();
    prepare_config(1, 1, 1);
    send_pixel('0);
    send_pixel('1);
    send_pixel(32'h5AC3_9E01);
  endtask

  task automatic test_zero_registers();
    prepare_config(0, 0, 0);
    send_pixel(rand_pixel());
    send_pixel(rand_pixel());
  endtask

  task automatic test_partial_cells();
    prepare_config(2, 5, 3);
    send_frames(1);
  endtask

  task automatic test_unused_index();
    finish_traffic();
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 2047)));
    cfg_we_i <= 1'b0;
    send_frames(1);
  endtask

  task automatic test_rate_clamp();
    prepare_config(15, 8, 8);
    send_frames(1);
  endtask

  // receiver blocked long enough for the block to back up into s_axis
  task automatic test_output_stall();
    prepare_config(1, 16, 4);
    rx_hold <= 1'b1;
    fork
      begin
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
    join_none
    send_frames(1);
  endtask

  task automatic test_random_frames();
    int unsigned tx_pct [4] = '{0, 54, 0, 23};
    int unsigned rx_pct [4] = '{0, 0, 54, 23};
    int unsigned sent, n_frames;
    logic [CFG_DATA_W-1:0] rate;
    for (int p = 0; p < 4; p++) begin
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
        if ($urandom_range(0, 3) == 0) begin
          rate = CFG_DATA_W'($urandom_range(0, 15));
        end else begin
          rate = CFG_DATA_W'($urandom_range(1, MAX_RATE_DEF));
        end
        prepare_config(rate, CFG_DATA_W'($urandom_range(1, 32)),
                       CFG_DATA_W'($urandom_range(1, 12)));
        tx_idle_pct  = tx_pct[p];
        rx_stall_pct = rx_pct[p];
        n_frames = $urandom_range(1, 2);
        send_frames(n_frames);
        sent += clamp_to(32'(width_reg), MAX_WIDTH_DEF) *
                clamp_to(32'(height_reg), HEIGHT_CAP) * n_frames;
      end
    end
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_avgs.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h last %b user %b",
                 $realtime, m_axis_tdata, m_axis_tlast, m_axis_tuser);
        err_count++;
      end else begin
        oldest_avg = pending_avgs.pop_front();
        for (int c = 0; c < NUM_CHAN; c++) begin
          if (m_axis_tdata[c*CHAN_W +: CHAN_W] !== oldest_avg.data[c*CHAN_W +: CHAN_W]) begin
            $display("%0t: channel %0d expected %h, actual %h", $realtime, c,
                     oldest_avg.data[c*CHAN_W +: CHAN_W], m_axis_tdata[c*CHAN_W +: CHAN_W]);
            err_count++;
          end
        end
        if (m_axis_tlast !== oldest_avg.row_end) begin
          $display("%0t: row_end expected %b, actual %b",
                   $realtime, oldest_avg.row_end, m_axis_tlast);
          err_count++;
        end
        if (m_axis_tuser !== oldest_avg.frame_end) begin
          $display("%0t: frame_end expected %b, actual %b",
                   $realtime, oldest_avg.frame_end, m_axis_tuser);
          err_count++;
        end
      end
    end
    m_axis_tready <= rst_ni && !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_pixel_frames();
    test_zero_registers();
    test_partial_cells();
    test_unused_index();
    test_rate_clamp();
    test_output_stall();
    test_random_frames();
    finish_traffic();
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
src/bad_pkg.sv
src/bad_ram.sv
src/bad_div.sv
src/box_average_downscale.sv
verif/tb.sv
